FILE: rtl/bilinear_texture_sampler_unit_macros.svh
// assertion macros shared by the texture sampler modules
// no dependencies; included by files that carry concurrent checks
`ifndef BILINEAR_TEXTURE_SAMPLER_UNIT_MACROS_SVH
`define BILINEAR_TEXTURE_SAMPLER_UNIT_MACROS_SVH

// same-cycle implication, disabled during reset
`define BTS_ASSERT_IMPLY(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("texture sampler: same-cycle check failed");

// next-cycle implication, disabled during reset
`define BTS_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("texture sampler: next-cycle check failed");

`endif

FILE: rtl/bts_pkg.sv
// constants, types and codes of the bilinear texture sampler
// no dependencies; used by every module of the block
`timescale 1ns / 1ps

package bts_pkg;

   localparam int MAX_WIDTH   = 256;
   localparam int MAX_HEIGHT  = 256;
   localparam int WEIGHT_BITS = 8;

   localparam int CFG_BITS       = 9;
   localparam int CSR_INDEX_BITS = 2;
   localparam int COORD_BITS     = 16;
   localparam int ADDR_BITS      = 16;
   localparam int STORE_DEPTH    = 2 ** ADDR_BITS;
   localparam int CHAN_BITS      = 8;
   localparam int NUM_CHAN       = 3;
   localparam int TEXEL_BITS     = NUM_CHAN * CHAN_BITS;
   localparam int NUM_TAPS       = 4;

   // clamped dimensions and texel coordinates
   localparam int WDIM_BITS = $clog2(MAX_WIDTH + 1);
   localparam int HDIM_BITS = $clog2(MAX_HEIGHT + 1);
   localparam int X_BITS    = $clog2(MAX_WIDTH);
   localparam int Y_BITS    = $clog2(MAX_HEIGHT);

   // weights run 0..2^WEIGHT_BITS inclusive
   localparam int WGT_BITS = WEIGHT_BITS + 1;
   localparam int SCALE    = 2 ** WEIGHT_BITS;
   localparam int H_BITS   = CHAN_BITS + WGT_BITS;
   localparam int V_BITS   = H_BITS + WGT_BITS;
   localparam int SAT_BITS = V_BITS - 2 * WEIGHT_BITS;

   localparam logic [CHAN_BITS-1:0] CHAN_MAX = '1;

   localparam int QUEUE_DEPTH = 2;
   localparam int PTR_BITS    = $clog2(QUEUE_DEPTH);

   localparam logic CMD_LOAD   = 1'b0;
   localparam logic CMD_SAMPLE = 1'b1;

   typedef enum logic [CSR_INDEX_BITS-1:0] {
      CSR_TEX_WIDTH       = 2'd0,
      CSR_TEX_HEIGHT      = 2'd1,
      CSR_TEXTURE_PRESENT = 2'd2
   } csr_index_type;

   typedef struct packed {
      logic                   is_sample;
      logic                   present;
      logic [WDIM_BITS-1:0]   width;
      logic [HDIM_BITS-1:0]   height;
      logic [X_BITS-1:0]      x0;
      logic [Y_BITS-1:0]      y0;
      logic [WEIGHT_BITS-1:0] fx;
      logic [WEIGHT_BITS-1:0] fy;
      logic [ADDR_BITS-1:0]   texel_index;
      logic [TEXEL_BITS-1:0]  texel;
   } item_type;

   typedef struct packed {
      logic valid;
      logic full;
   } queue_status_type;

endpackage

FILE: rtl/bts_front.sv
// front end: control registers, command accept, texel coordinate multiply
// depends on bts_pkg; feeds bts_queue
`timescale 1ns / 1ps

module bts_front (
   input  logic                               clock,
   input  logic                               reset,
   input  logic                               csr_write_en,
   input  logic [bts_pkg::CSR_INDEX_BITS-1:0] csr_index,
   input  logic [bts_pkg::CFG_BITS-1:0]       csr_wdata,
   input  logic                               start,
   output logic                               busy,
   input  logic                               req_cmd,
   input  logic [bts_pkg::ADDR_BITS-1:0]      req_texel_index,
   input  logic [bts_pkg::CHAN_BITS-1:0]      req_load_red,
   input  logic [bts_pkg::CHAN_BITS-1:0]      req_load_green,
   input  logic [bts_pkg::CHAN_BITS-1:0]      req_load_blue,
   input  logic [bts_pkg::COORD_BITS-1:0]     req_coord_u,
   input  logic [bts_pkg::COORD_BITS-1:0]     req_coord_v,
   input  bts_pkg::queue_status_type          q_status,
   output logic                               push,
   output bts_pkg::item_type                  item
);

   localparam int XS_BITS = bts_pkg::COORD_BITS + bts_pkg::WDIM_BITS;
   localparam int YS_BITS = bts_pkg::COORD_BITS + bts_pkg::HDIM_BITS;
   localparam int FRAC_LSB = bts_pkg::COORD_BITS - bts_pkg::WEIGHT_BITS;

   logic [bts_pkg::CFG_BITS-1:0]  tex_width_ff, tex_width_in;
   logic [bts_pkg::CFG_BITS-1:0]  tex_height_ff, tex_height_in;
   logic                          present_ff, present_in;
   logic                          f_valid_ff, f_valid_in;
   bts_pkg::item_type             f_item_ff, f_item_in;
   bts_pkg::item_type             new_item;
   logic [bts_pkg::WDIM_BITS-1:0] width_c;
   logic [bts_pkg::HDIM_BITS-1:0] height_c;
   logic [XS_BITS-1:0]            xs;
   logic [YS_BITS-1:0]            ys;
   logic                          accept;

   always_comb begin
      tex_width_in  = tex_width_ff;
      tex_height_in = tex_height_ff;
      present_in    = present_ff;
      if (csr_write_en) begin
         unique case (bts_pkg::csr_index_type'(csr_index))
            bts_pkg::CSR_TEX_WIDTH:       tex_width_in  = csr_wdata;
            bts_pkg::CSR_TEX_HEIGHT:      tex_height_in = csr_wdata;
            bts_pkg::CSR_TEXTURE_PRESENT: present_in    = csr_wdata[0];
            default: ;
         endcase
      end
   end

   // zero reads as one, oversize saturates
   always_comb begin
      if (tex_width_ff == '0) begin
         width_c = bts_pkg::WDIM_BITS'(1);
      end else if (int'(tex_width_ff) > bts_pkg::MAX_WIDTH) begin
         width_c = bts_pkg::WDIM_BITS'(bts_pkg::MAX_WIDTH);
      end else begin
         width_c = bts_pkg::WDIM_BITS'(tex_width_ff);
      end
      if (tex_height_ff == '0) begin
         height_c = bts_pkg::HDIM_BITS'(1);
      end else if (int'(tex_height_ff) > bts_pkg::MAX_HEIGHT) begin
         height_c = bts_pkg::HDIM_BITS'(bts_pkg::MAX_HEIGHT);
      end else begin
         height_c = bts_pkg::HDIM_BITS'(tex_height_ff);
      end
   end

   always_comb begin
      xs = XS_BITS'(req_coord_u) * XS_BITS'(width_c);
      ys = YS_BITS'(req_coord_v) * YS_BITS'(height_c);
      new_item.is_sample   = (req_cmd == bts_pkg::CMD_SAMPLE);
      new_item.present     = present_ff;
      new_item.width       = width_c;
      new_item.height      = height_c;
      new_item.x0          = xs[bts_pkg::COORD_BITS +: bts_pkg::X_BITS];
      new_item.y0          = ys[bts_pkg::COORD_BITS +: bts_pkg::Y_BITS];
      new_item.fx          = xs[FRAC_LSB +: bts_pkg::WEIGHT_BITS];
      new_item.fy          = ys[FRAC_LSB +: bts_pkg::WEIGHT_BITS];
      new_item.texel_index = req_texel_index;
      new_item.texel       = {req_load_red, req_load_green, req_load_blue};
   end

   assign busy   = f_valid_ff && q_status.full;
   assign accept = start && !busy;
   assign push   = f_valid_ff && !q_status.full;
   assign item   = f_item_ff;

   always_comb begin
      f_valid_in = f_valid_ff;
      f_item_in  = f_item_ff;
      if (accept) begin
         f_valid_in = 1'b1;
         f_item_in  = new_item;
      end else if (push) begin
         f_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         tex_width_ff  <= bts_pkg::CFG_BITS'(1);
         tex_height_ff <= bts_pkg::CFG_BITS'(1);
         present_ff    <= 1'b0;
         f_valid_ff    <= 1'b0;
      end else begin
         tex_width_ff  <= tex_width_in;
         tex_height_ff <= tex_height_in;
         present_ff    <= present_in;
         f_valid_ff    <= f_valid_in;
      end
      f_item_ff <= f_item_in;
   end

endmodule

FILE: rtl/bts_queue.sv
// short fifo between front end and back end
// depends on bts_pkg and the assertion macro header
`timescale 1ns / 1ps
`include "bilinear_texture_sampler_unit_macros.svh"

module bts_queue (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      push,
   input  bts_pkg::item_type         push_item,
   input  logic                      pop,
   output bts_pkg::item_type         head,
   output bts_pkg::queue_status_type status
);

   localparam int CNT_BITS = bts_pkg::PTR_BITS + 1;

   bts_pkg::item_type             entries_ff [bts_pkg::QUEUE_DEPTH];
   logic [bts_pkg::PTR_BITS-1:0]  wr_ptr_ff, wr_ptr_in;
   logic [bts_pkg::PTR_BITS-1:0]  rd_ptr_ff, rd_ptr_in;
   logic [CNT_BITS-1:0]           count_ff, count_in;

   assign status.valid = (count_ff != '0);
   assign status.full  = (count_ff == CNT_BITS'(bts_pkg::QUEUE_DEPTH));
   assign head         = entries_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = push ? wr_ptr_ff + 1'b1 : wr_ptr_ff;
      rd_ptr_in = pop ? rd_ptr_ff + 1'b1 : rd_ptr_ff;
      count_in  = count_ff;
      if (push && !pop) begin
         count_in = count_ff + 1'b1;
      end else if (pop && !push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
      if (push) begin
         entries_ff[wr_ptr_ff] <= push_item;
      end
   end

   `BTS_ASSERT_IMPLY(a_queue_no_overflow, clock, reset, push, !status.full || pop)
   `BTS_ASSERT_IMPLY(a_queue_no_underflow, clock, reset, pop, status.valid)

endmodule

FILE: rtl/bts_texmem.sv
// texel store: two copies with two read ports each, one shared write port
// depends on bts_pkg; read data is registered
`timescale 1ns / 1ps

module bts_texmem (
   input  logic                                                     clock,
   input  logic                                                     wr_en,
   input  logic [bts_pkg::ADDR_BITS-1:0]                            wr_addr,
   input  logic [bts_pkg::TEXEL_BITS-1:0]                           wr_data,
   input  logic [bts_pkg::NUM_TAPS-1:0][bts_pkg::ADDR_BITS-1:0]     rd_addr,
   output logic [bts_pkg::NUM_TAPS-1:0][bts_pkg::TEXEL_BITS-1:0]    rd_data
);

   logic [bts_pkg::TEXEL_BITS-1:0] copy0_ff [bts_pkg::STORE_DEPTH];
   logic [bts_pkg::TEXEL_BITS-1:0] copy1_ff [bts_pkg::STORE_DEPTH];
   logic [bts_pkg::NUM_TAPS-1:0][bts_pkg::TEXEL_BITS-1:0] rd_data_ff;

   // both copies take every load so each serves two of the four taps
   always_ff @(posedge clock) begin
      if (wr_en) begin
         copy0_ff[wr_addr] <= wr_data;
         copy1_ff[wr_addr] <= wr_data;
      end
      rd_data_ff[0] <= copy0_ff[rd_addr[0]];
      rd_data_ff[1] <= copy0_ff[rd_addr[1]];
      rd_data_ff[2] <= copy1_ff[rd_addr[2]];
      rd_data_ff[3] <= copy1_ff[rd_addr[3]];
   end

   assign rd_data = rd_data_ff;

endmodule

FILE: rtl/bts_back.sv
// back end: neighbor addresses, texel fetch or load write, bilinear blend
// depends on bts_pkg, bts_texmem and the assertion macro header
`timescale 1ns / 1ps
`include "bilinear_texture_sampler_unit_macros.svh"

module bts_back (
   input  logic                          clock,
   input  logic                          reset,
   input  bts_pkg::queue_status_type     q_status,
   input  bts_pkg::item_type             head,
   output logic                          pop,
   output logic                          rsp_valid,
   output logic [bts_pkg::CHAN_BITS-1:0] rsp_out_red,
   output logic [bts_pkg::CHAN_BITS-1:0] rsp_out_green,
   output logic [bts_pkg::CHAN_BITS-1:0] rsp_out_blue
);

   localparam int ROW_BITS = bts_pkg::Y_BITS + bts_pkg::WDIM_BITS;
   localparam int NC       = bts_pkg::NUM_CHAN;
   localparam int CB       = bts_pkg::CHAN_BITS;

   // address stage
   logic [bts_pkg::X_BITS-1:0]  x1;
   logic [bts_pkg::Y_BITS-1:0]  y1;
   logic [ROW_BITS-1:0]         row0, row1;
   logic [bts_pkg::NUM_TAPS-1:0][bts_pkg::ADDR_BITS-1:0] a_addr_ff, a_addr_in;
   logic                           a_valid_ff;
   logic                           a_sample_ff;
   logic                           a_present_ff;
   logic [bts_pkg::WEIGHT_BITS-1:0] a_fx_ff, a_fy_ff;
   logic [bts_pkg::TEXEL_BITS-1:0]  a_texel_ff;

   // fetch stage
   logic [bts_pkg::NUM_TAPS-1:0][bts_pkg::TEXEL_BITS-1:0] tex_data;
   logic                           m_valid_ff;
   logic                           m_present_ff;
   logic [bts_pkg::WEIGHT_BITS-1:0] m_fx_ff, m_fy_ff;

   // horizontal blend stage
   logic [bts_pkg::WGT_BITS-1:0]             inv_fx, wfx;
   logic [NC-1:0][bts_pkg::H_BITS-1:0]       h_top_ff, h_top_in;
   logic [NC-1:0][bts_pkg::H_BITS-1:0]       h_bot_ff, h_bot_in;
   logic                                     h_valid_ff;
   logic                                     h_present_ff;
   logic [bts_pkg::WEIGHT_BITS-1:0]          h_fy_ff;

   // vertical blend stage
   logic [bts_pkg::WGT_BITS-1:0]             inv_fy, wfy;
   logic [NC-1:0][bts_pkg::V_BITS-1:0]       v_acc_ff, v_acc_in;
   logic                                     v_valid_ff;
   logic                                     v_present_ff;

   // output register
   logic [bts_pkg::SAT_BITS-1:0]             shifted [NC];
   logic [NC-1:0][CB-1:0]                    rsp_chan_ff, rsp_chan_in;
   logic                                     rsp_valid_ff;

   assign pop = q_status.valid;

   // right and lower neighbors wrap to column or row zero
   always_comb begin
      if (int'(head.x0) + 1 >= int'(head.width)) begin
         x1 = '0;
      end else begin
         x1 = bts_pkg::X_BITS'(head.x0 + 1'b1);
      end
      if (int'(head.y0) + 1 >= int'(head.height)) begin
         y1 = '0;
      end else begin
         y1 = bts_pkg::Y_BITS'(head.y0 + 1'b1);
      end
      row0 = ROW_BITS'(head.y0) * ROW_BITS'(head.width);
      row1 = ROW_BITS'(y1) * ROW_BITS'(head.width);
      a_addr_in[0] = bts_pkg::ADDR_BITS'(row0 + ROW_BITS'(head.x0));
      a_addr_in[1] = bts_pkg::ADDR_BITS'(row0 + ROW_BITS'(x1));
      a_addr_in[2] = bts_pkg::ADDR_BITS'(row1 + ROW_BITS'(head.x0));
      a_addr_in[3] = bts_pkg::ADDR_BITS'(row1 + ROW_BITS'(x1));
      // a load writes through the first tap's address
      if (!head.is_sample) begin
         a_addr_in[0] = head.texel_index;
      end
   end

   bts_texmem u_texmem (
      .clock   (clock),
      .wr_en   (a_valid_ff && !a_sample_ff),
      .wr_addr (a_addr_ff[0]),
      .wr_data (a_texel_ff),
      .rd_addr (a_addr_ff),
      .rd_data (tex_data)
   );

   always_comb begin
      inv_fx = bts_pkg::WGT_BITS'(bts_pkg::SCALE) - bts_pkg::WGT_BITS'(m_fx_ff);
      wfx    = bts_pkg::WGT_BITS'(m_fx_ff);
      for (int c = 0; c < NC; c++) begin
         h_top_in[c] = bts_pkg::H_BITS'(tex_data[0][c*CB +: CB]) * bts_pkg::H_BITS'(inv_fx)
                     + bts_pkg::H_BITS'(tex_data[1][c*CB +: CB]) * bts_pkg::H_BITS'(wfx);
         h_bot_in[c] = bts_pkg::H_BITS'(tex_data[2][c*CB +: CB]) * bts_pkg::H_BITS'(inv_fx)
                     + bts_pkg::H_BITS'(tex_data[3][c*CB +: CB]) * bts_pkg::H_BITS'(wfx);
      end
   end

   always_comb begin
      inv_fy = bts_pkg::WGT_BITS'(bts_pkg::SCALE) - bts_pkg::WGT_BITS'(h_fy_ff);
      wfy    = bts_pkg::WGT_BITS'(h_fy_ff);
      for (int c = 0; c < NC; c++) begin
         // rounding half is folded in here, once
         v_acc_in[c] = bts_pkg::V_BITS'(h_top_ff[c]) * bts_pkg::V_BITS'(inv_fy)
                     + bts_pkg::V_BITS'(h_bot_ff[c]) * bts_pkg::V_BITS'(wfy)
                     + (bts_pkg::V_BITS'(1) << (2 * bts_pkg::WEIGHT_BITS - 1));
      end
   end

   always_comb begin
      for (int c = 0; c < NC; c++) begin
         shifted[c] = v_acc_ff[c][2 * bts_pkg::WEIGHT_BITS +: bts_pkg::SAT_BITS];
         if (!v_present_ff || (shifted[c] > bts_pkg::SAT_BITS'(bts_pkg::CHAN_MAX))) begin
            rsp_chan_in[c] = bts_pkg::CHAN_MAX;
         end else begin
            rsp_chan_in[c] = CB'(shifted[c]);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         a_valid_ff   <= 1'b0;
         m_valid_ff   <= 1'b0;
         h_valid_ff   <= 1'b0;
         v_valid_ff   <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         a_valid_ff   <= pop;
         m_valid_ff   <= a_valid_ff && a_sample_ff;
         h_valid_ff   <= m_valid_ff;
         v_valid_ff   <= h_valid_ff;
         rsp_valid_ff <= v_valid_ff;
      end
      a_sample_ff  <= head.is_sample;
      a_present_ff <= head.present;
      a_fx_ff      <= head.fx;
      a_fy_ff      <= head.fy;
      a_texel_ff   <= head.texel;
      a_addr_ff    <= a_addr_in;
      m_present_ff <= a_present_ff;
      m_fx_ff      <= a_fx_ff;
      m_fy_ff      <= a_fy_ff;
      h_top_ff     <= h_top_in;
      h_bot_ff     <= h_bot_in;
      h_present_ff <= m_present_ff;
      h_fy_ff      <= m_fy_ff;
      v_acc_ff     <= v_acc_in;
      v_present_ff <= h_present_ff;
      rsp_chan_ff  <= rsp_chan_in;
   end

   assign rsp_valid     = rsp_valid_ff;
   assign rsp_out_red   = rsp_chan_ff[2];
   assign rsp_out_green = rsp_chan_ff[1];
   assign rsp_out_blue  = rsp_chan_ff[0];

   `BTS_ASSERT_NEXT(a_load_gives_no_result, clock, reset, a_valid_ff && !a_sample_ff, !m_valid_ff)
   `BTS_ASSERT_NEXT(a_absent_gives_white, clock, reset, v_valid_ff && !v_present_ff, rsp_valid && rsp_out_red == bts_pkg::CHAN_MAX && rsp_out_blue == bts_pkg::CHAN_MAX)

endmodule

FILE: rtl/bilinear_texture_sampler_unit.sv
// bilinear rgb8 texture sampler, top level
// depends on bts_pkg, bts_front, bts_queue, bts_back
`timescale 1ns / 1ps

// Usage:
//   Commands enter on start/busy; a command transfers at a clock edge with
//   start high and busy low. req_cmd low loads one texel (req_texel_index,
//   req_load_*), req_cmd high samples at (req_coord_u, req_coord_v) in Q0.16.
//   Loads produce no result. Each sample produces one result on rsp_out_*,
//   marked by rsp_valid for exactly one cycle; the receiver cannot stall.
//   A sample passes the front register, queue, address, texel fetch, two
//   blend stages and output register before rsp_valid rises.
//   Throughput: one command per cycle; four neighbor taps come from two
//   dual-read copies of the texel store, so busy stays low in steady use.
//   Control registers are written over csr_write_en/csr_index/csr_wdata
//   while no command is in flight: width, height, texture present.
//   Reset clears the control registers (1, 1, absent) and all pipeline
//   valid bits; the texel store is not cleared and must be loaded before
//   a sample reads it. With no texture present a sample answers white.
module bilinear_texture_sampler_unit (
   input  logic                               clock,
   input  logic                               reset,
   input  logic                               csr_write_en,
   input  logic [bts_pkg::CSR_INDEX_BITS-1:0] csr_index,
   input  logic [bts_pkg::CFG_BITS-1:0]       csr_wdata,
   input  logic                               start,
   output logic                               busy,
   input  logic                               req_cmd,
   input  logic [bts_pkg::ADDR_BITS-1:0]      req_texel_index,
   input  logic [bts_pkg::CHAN_BITS-1:0]      req_load_red,
   input  logic [bts_pkg::CHAN_BITS-1:0]      req_load_green,
   input  logic [bts_pkg::CHAN_BITS-1:0]      req_load_blue,
   input  logic [bts_pkg::COORD_BITS-1:0]     req_coord_u,
   input  logic [bts_pkg::COORD_BITS-1:0]     req_coord_v,
   output logic                               rsp_valid,
   output logic [bts_pkg::CHAN_BITS-1:0]      rsp_out_red,
   output logic [bts_pkg::CHAN_BITS-1:0]      rsp_out_green,
   output logic [bts_pkg::CHAN_BITS-1:0]      rsp_out_blue
);

   bts_pkg::queue_status_type q_status;
   bts_pkg::item_type         push_item;
   bts_pkg::item_type         head;
   logic                      push;
   logic                      pop;

   bts_front u_front (
      .clock           (clock),
      .reset           (reset),
      .csr_write_en    (csr_write_en),
      .csr_index       (csr_index),
      .csr_wdata       (csr_wdata),
      .start           (start),
      .busy            (busy),
      .req_cmd         (req_cmd),
      .req_texel_index (req_texel_index),
      .req_load_red    (req_load_red),
      .req_load_green  (req_load_green),
      .req_load_blue   (req_load_blue),
      .req_coord_u     (req_coord_u),
      .req_coord_v     (req_coord_v),
      .q_status        (q_status),
      .push            (push),
      .item            (push_item)
   );

   bts_queue u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (push),
      .push_item (push_item),
      .pop       (pop),
      .head      (head),
      .status    (q_status)
   );

   bts_back u_back (
      .clock         (clock),
      .reset         (reset),
      .q_status      (q_status),
      .head          (head),
      .pop           (pop),
      .rsp_valid     (rsp_valid),
      .rsp_out_red   (rsp_out_red),
      .rsp_out_green (rsp_out_green),
      .rsp_out_blue  (rsp_out_blue)
   );

endmodule
